// ===== sv/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon crossing-number block.
// Used by pip_front, pip_queue, pip_back and point_in_polygon_test_core.
// No dependencies.
package pip_pkg;

  localparam int CoordWidth = 32;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * DiffWidth;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // one edge, prepared for the cross-multiplication
  typedef struct packed {
    logic                        straddle;
    logic                        d_pos;
    logic signed [DiffWidth-1:0] d;
    logic signed [DiffWidth-1:0] ax;
    logic signed [DiffWidth-1:0] bx;
    logic signed [DiffWidth-1:0] by;
  } seg_t;

  // one vertex item after classification
  typedef struct packed {
    seg_t seg_a;
    seg_t seg_b;
    logic last;
  } entry_t;

  // one edge after the multiply stage
  typedef struct packed {
    logic                        straddle;
    logic                        d_pos;
    logic signed [ProdWidth-1:0] lhs;
    logic signed [ProdWidth-1:0] rhs;
  } prod_t;

  typedef struct packed {
    prod_t prod_a;
    prod_t prod_b;
    logic  last;
  } prod_entry_t;

  // edge from (xj,yj) to (xi,yi) against test point (tx,ty)
  function automatic seg_t make_seg(
    input logic signed [CoordWidth-1:0] xj,
    input logic signed [CoordWidth-1:0] yj,
    input logic signed [CoordWidth-1:0] xi,
    input logic signed [CoordWidth-1:0] yi,
    input logic signed [CoordWidth-1:0] tx,
    input logic signed [CoordWidth-1:0] ty
  );
    seg_t s;
    s.straddle = (yi > ty) != (yj > ty);
    s.d        = DiffWidth'(yj) - DiffWidth'(yi);
    // d is nonzero whenever the edge straddles the ray
    s.d_pos    = ~s.d[DiffWidth-1];
    s.ax       = DiffWidth'(tx) - DiffWidth'(xi);
    s.bx       = DiffWidth'(xj) - DiffWidth'(xi);
    s.by       = DiffWidth'(ty) - DiffWidth'(yi);
    return s;
  endfunction

endpackage

// ===== sv/pip_front.sv =====
// Front end: takes vertex beats, keeps polygon state, and prepares both edges.
// Depends on pip_pkg.
module pip_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pip_pkg::CoordWidth-1:0] vertex_x_i,
  input  logic signed [pip_pkg::CoordWidth-1:0] vertex_y_i,
  input  logic signed [pip_pkg::CoordWidth-1:0] point_x_i,
  input  logic signed [pip_pkg::CoordWidth-1:0] point_y_i,
  input  logic                                  last_vertex_i,
  input  logic                                  full_i,
  output logic                                  push_o,
  output pip_pkg::entry_t                       entry_o
);

  logic signed [pip_pkg::CoordWidth-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [pip_pkg::CoordWidth-1:0] held_px_q, held_py_q;
  logic signed [pip_pkg::CoordWidth-1:0] tx, ty, fx, fy;
  logic                                  in_poly_q, in_poly_d;
  logic                                  accept;
  pip_pkg::seg_t                         seg_a, seg_b;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign push_o     = accept;

  // on the first vertex the point and the first vertex come straight from the beat
  assign tx = in_poly_q ? held_px_q : point_x_i;
  assign ty = in_poly_q ? held_py_q : point_y_i;
  assign fx = in_poly_q ? first_x_q : vertex_x_i;
  assign fy = in_poly_q ? first_y_q : vertex_y_i;

  always_comb begin
    seg_a = pip_pkg::make_seg(prev_x_q, prev_y_q, vertex_x_i, vertex_y_i, tx, ty);
    seg_b = pip_pkg::make_seg(vertex_x_i, vertex_y_i, fx, fy, tx, ty);
    seg_a.straddle = seg_a.straddle & in_poly_q;
    seg_b.straddle = seg_b.straddle & last_vertex_i;
    entry_o.seg_a = seg_a;
    entry_o.seg_b = seg_b;
    entry_o.last  = last_vertex_i;
  end

  assign in_poly_d = ~last_vertex_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_poly_q <= 1'b0;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      held_px_q <= '0;
      held_py_q <= '0;
    end else if (accept) begin
      in_poly_q <= in_poly_d;
      prev_x_q  <= vertex_x_i;
      prev_y_q  <= vertex_y_i;
      if (!in_poly_q) begin
        first_x_q <= vertex_x_i;
        first_y_q <= vertex_y_i;
        held_px_q <= point_x_i;
        held_py_q <= point_y_i;
      end
    end
  end

endmodule

// ===== sv/pip_queue.sv =====
// Short queue of classified vertex entries between front and back ends.
// Depends on pip_pkg.
module pip_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pip_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pip_pkg::entry_t rdata_o
);

  pip_pkg::entry_t                   mem_q [pip_pkg::QueueDepth];
  logic [pip_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [pip_pkg::QueueCntW-1:0]     count_q, count_d;
  logic                              do_push, do_pop;

  assign full_o  = (count_q == pip_pkg::QueueCntW'(pip_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == pip_pkg::QueuePtrW'(pip_pkg::QueueDepth - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == pip_pkg::QueuePtrW'(pip_pkg::QueueDepth - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pip_pkg::QueueCntW'(pip_pkg::QueueDepth))
    else $error("queue count above depth");

  a_push_moves_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("push without pop did not grow the queue");

endmodule

// ===== sv/pip_back.sv =====
// Back end: cross-multiplies both edges, then compares, tracks parity and
// holds the result beat. Depends on pip_pkg.
module pip_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  pip_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            inside_res_o
);

  pip_pkg::prod_entry_t s1_q, s1_d;
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_take, s1_ready;
  logic                 cross_a, cross_b, flip;
  logic                 parity_q, parity_d;
  logic                 out_valid_q, out_valid_d;
  logic                 inside_q, inside_d;

  // a last vertex needs room in the output register, other vertices go straight through
  assign s1_take  = s1_valid_q & (~s1_q.last | ~out_valid_q | out_ready_i);
  assign s1_ready = ~s1_valid_q | s1_take;
  assign pop_o    = ~empty_i & s1_ready;

  always_comb begin
    s1_d.prod_a.straddle = entry_i.seg_a.straddle;
    s1_d.prod_a.d_pos    = entry_i.seg_a.d_pos;
    s1_d.prod_a.lhs      = entry_i.seg_a.ax * entry_i.seg_a.d;
    s1_d.prod_a.rhs      = entry_i.seg_a.bx * entry_i.seg_a.by;
    s1_d.prod_b.straddle = entry_i.seg_b.straddle;
    s1_d.prod_b.d_pos    = entry_i.seg_b.d_pos;
    s1_d.prod_b.lhs      = entry_i.seg_b.ax * entry_i.seg_b.d;
    s1_d.prod_b.rhs      = entry_i.seg_b.bx * entry_i.seg_b.by;
    s1_d.last            = entry_i.last;
  end

  assign s1_valid_d = pop_o ? 1'b1 : (s1_take ? 1'b0 : s1_valid_q);

  // sign of d picks the direction of the compare
  assign cross_a = s1_q.prod_a.straddle &
                   (s1_q.prod_a.d_pos ? (s1_q.prod_a.lhs < s1_q.prod_a.rhs)
                                      : (s1_q.prod_a.rhs < s1_q.prod_a.lhs));
  assign cross_b = s1_q.prod_b.straddle &
                   (s1_q.prod_b.d_pos ? (s1_q.prod_b.lhs < s1_q.prod_b.rhs)
                                      : (s1_q.prod_b.rhs < s1_q.prod_b.lhs));
  assign flip    = cross_a ^ cross_b;

  always_comb begin
    parity_d    = parity_q;
    inside_d    = inside_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (s1_take) begin
      if (s1_q.last) begin
        out_valid_d = 1'b1;
        inside_d    = parity_q ^ flip;
        parity_d    = 1'b0;
      end else begin
        parity_d = parity_q ^ flip;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= s1_d;
    end
    inside_q <= inside_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      parity_q    <= parity_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  a_parity_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_take && s1_q.last) |=> (parity_q == 1'b0))
    else $error("parity not cleared after closing vertex");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (inside_q == $past(inside_q)))
    else $error("pending result overwritten");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_take && s1_q.last))
    else $error("result raised without a closing vertex");

endmodule

// ===== sv/point_in_polygon_test_core.sv =====
// Point-in-polygon test by the even-odd crossing rule, top level.
// Depends on pip_pkg, pip_front, pip_queue and pip_back.
//
// Vertices stream in one per beat, signed Q16.16; the test point is taken from
// the first vertex beat of each polygon and last_vertex closes the polygon. The
// block takes one vertex per clock cycle, sustained, while the output side is
// not stalled. A result beat is registered through the queue, the multiply
// register and the output register after its closing vertex is taken; the
// per-cycle rate is set by the back end, which cross-multiplies the current edge
// and the closing edge in parallel in one stage and compares in the next. While
// a result waits to be taken, vertices that do not close a polygon keep flowing;
// the next closing vertex is held in the multiply register and the two-entry
// queue takes two more beats behind it before the input stalls.
module point_in_polygon_test_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pip_pkg::CoordWidth-1:0] vertex_x_i,
  input  logic signed [pip_pkg::CoordWidth-1:0] vertex_y_i,
  input  logic signed [pip_pkg::CoordWidth-1:0] point_x_i,
  input  logic signed [pip_pkg::CoordWidth-1:0] point_y_i,
  input  logic                                  last_vertex_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  inside_res_o
);

  logic            push, full, pop, empty;
  pip_pkg::entry_t wr_entry, rd_entry;

  pip_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .last_vertex_i (last_vertex_i),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (wr_entry)
  );

  pip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (rd_entry)
  );

  pip_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (rd_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o)
  );

endmodule
